// ----- design/diff_drive_encoder_odometry_unit_defines.svh -----
// assertion macros for the odometry unit
`ifndef DIFF_DRIVE_ENCODER_ODOMETRY_UNIT_DEFINES_SVH
`define DIFF_DRIVE_ENCODER_ODOMETRY_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DDEO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DDEO_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DDEO_ASSERT(lbl, prop, msg)
`define DDEO_NEVER(lbl, cond, msg)
`endif

`endif

// ----- design/ddeo_pkg.sv -----
`default_nettype none
package ddeo_pkg;

	localparam int ENC_BITS = 12;
	localparam int ANGLE_BITS = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int CORD_W = ENC_BITS + 35;

	localparam logic [31:0] MPC_RESET = 32'd819200;
	localparam logic [31:0] TPM_RESET = 32'd4557108;
	localparam logic [31:0] CORDIC_GAIN = 32'd10188014;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_CAPTURE = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [1:0] REG_MPC = 2'd0;
	localparam logic [1:0] REG_TPM = 2'd1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [ENC_BITS-1:0] left_angle;
		logic [ENC_BITS-1:0] right_angle;
		logic signed [31:0] load_x;
		logic signed [31:0] load_y;
		logic [ANGLE_BITS-1:0] load_heading;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [ANGLE_BITS-1:0] heading;
	} pose_t;

	function automatic logic [29:0] atan_q32(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- design/ddeo_cordic.sv -----
`default_nettype none
module ddeo_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [ddeo_pkg::CORD_W-1:0] c_init,
	input wire logic [ddeo_pkg::ANGLE_BITS-1:0] angle,
	output logic done,
	output logic signed [ddeo_pkg::CORD_W-1:0] sin_out,
	output logic signed [ddeo_pkg::CORD_W-1:0] cos_out
);
	localparam int W = ddeo_pkg::CORD_W;
	localparam logic [4:0] LAST_STEP = 5'(ddeo_pkg::CORDIC_STEPS - 1);

	logic busy_q;
	logic done_q;
	logic [4:0] step_q;
	logic signed [W-1:0] c_q;
	logic signed [W-1:0] s_q;
	logic signed [32:0] z_q;

	logic [31:0] z32;
	logic flip;
	logic signed [W-1:0] cs;
	logic signed [W-1:0] ss;
	logic signed [32:0] at;

	assign z32 = {angle, {(32 - ddeo_pkg::ANGLE_BITS){1'b0}}};
	assign flip = (z32[31:30] == 2'b01) || (z32[31:30] == 2'b10);
	assign cs = c_q >>> step_q;
	assign ss = s_q >>> step_q;
	assign at = $signed({3'b000, ddeo_pkg::atan_q32(step_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			c_q <= flip ? -c_init : c_init;
			s_q <= '0;
			z_q <= 33'($signed(flip ? {~z32[31], z32[30:0]} : z32));
		end else if (busy_q) begin
			if (!z_q[32]) begin
				c_q <= c_q - ss;
				s_q <= s_q + cs;
				z_q <= z_q - at;
			end else begin
				c_q <= c_q + ss;
				s_q <= s_q - cs;
				z_q <= z_q + at;
			end
		end
	end

	assign done = done_q;
	assign sin_out = s_q;
	assign cos_out = c_q;
endmodule
`default_nettype wire

// ----- design/diff_drive_encoder_odometry_unit.sv -----
// Differential-drive odometry. Each request carries a command: an encoder sample
// updates heading and position from the two wheel angle deltas, a load sets the
// pose, a capture stores new encoder baselines. Every request yields exactly one
// response with the pose after it. A sample passes through two bit-serial
// shift-add multiplies (wheel travel by mm_per_count, then heading and mean
// travel scaling), a 24-step iterative CORDIC whose end is flagged by a
// registered done, then the pose update and the registered response; other
// commands go straight to the response. A new request is accepted only once
// the previous one has registered its response. The result sits in an output
// register, so the next request may start while it waits. Configuration writes
// belong between requests, while no request is in flight.
`default_nettype none
`include "diff_drive_encoder_odometry_unit_defines.svh"
module diff_drive_encoder_odometry_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire ddeo_pkg::cmd_t cmd_data,
	output logic pose_valid,
	input wire logic pose_ready,
	output ddeo_pkg::pose_t pose_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int E = ddeo_pkg::ENC_BITS;
	localparam int A = ddeo_pkg::ANGLE_BITS;
	localparam int W = ddeo_pkg::CORD_W;
	localparam int WP = E + 34;
	localparam int WH = 56;
	localparam int WM = E + 49;
	localparam int SW = W - 7;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_CORD = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;

	localparam logic signed [E+2:0] HALF = (E+3)'(1) <<< (E - 1);
	localparam logic signed [E+2:0] FULL = (E+3)'(1) <<< E;
	localparam logic signed [SW-1:0] SMAX = SW'(32'sh7fffffff);
	localparam logic signed [SW-1:0] SMIN = SW'($signed(32'h80000000));

	logic [2:0] state_q;
	logic [4:0] cnt_q;
	logic [31:0] mpc_q;
	logic [31:0] tpm_q;
	logic [E-1:0] lbase_q;
	logic [E-1:0] rbase_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic [A-1:0] hd_q;
	logic pose_valid_q;
	ddeo_pkg::pose_t pose_q;

	logic signed [WP-1:0] mcd_q;
	logic signed [WP-1:0] mcs_q;
	logic signed [WP-1:0] accd_q;
	logic signed [WP-1:0] accs_q;
	logic [31:0] mpl_q;
	logic [31:0] gain_q;
	logic [WH-1:0] mch_q;
	logic [WH-1:0] acch_q;
	logic signed [WM-1:0] mcm_q;
	logic signed [WM-1:0] accm_q;

	logic accept;
	logic signed [E+2:0] dl;
	logic signed [E+2:0] dr;
	logic signed [WP-1:0] s_rnd;
	logic signed [WP-1:0] m16;
	logic [WH-1:0] h_rnd;
	logic [A-1:0] hd_new;
	logic signed [WM-1:0] c_rnd;
	logic signed [W-1:0] c_init;
	logic cord_start;
	logic cord_done;
	logic signed [W-1:0] sin_v;
	logic signed [W-1:0] cos_v;
	logic signed [W-1:0] sin_r;
	logic signed [W-1:0] cos_r;
	logic signed [SW-1:0] x_sum;
	logic signed [SW-1:0] y_sum;
	logic fin_go;

	function automatic logic signed [E+2:0] wrap_delta(input logic [E-1:0] oldv,
		input logic [E-1:0] newv);
		logic signed [E+2:0] d;
		d = $signed({3'b000, oldv}) - $signed({3'b000, newv});
		if (d > HALF) begin
			d = d - FULL;
		end else if (d < -HALF) begin
			d = d + FULL;
		end
		return d;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		logic signed [31:0] r;
		if (v > SMAX) begin
			r = 32'sh7fffffff;
		end else if (v < SMIN) begin
			r = $signed(32'h80000000);
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	assign cmd_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept = cmd_valid && cmd_ready;

	assign dl = wrap_delta(lbase_q, cmd_data.left_angle);
	assign dr = wrap_delta(rbase_q, cmd_data.right_angle);

	assign s_rnd = accs_q + $signed(WP'(256));
	assign m16 = s_rnd >>> 9;
	// last partial product folded in so the heading is complete on the final count
	assign h_rnd = acch_q + (mpl_q[0] ? mch_q : WH'(0)) + (WH'(1) << (55 - A));
	assign hd_new = hd_q + h_rnd[55 -: A];
	assign c_rnd = accm_q + $signed(WM'(32768));
	assign c_init = W'(c_rnd >>> 16);
	assign cord_start = (state_q == ST_MUL2) && (cnt_q == 5'd31);

	assign sin_r = (sin_v + $signed(W'(128))) >>> 8;
	assign cos_r = (cos_v + $signed(W'(128))) >>> 8;
	assign x_sum = SW'(x_q) + SW'(sin_r);
	assign y_sum = SW'(y_q) + SW'(cos_r);
	assign fin_go = (state_q == ST_FIN) && (!pose_valid_q || pose_ready);

	ddeo_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cord_start),
		.c_init(c_init),
		.angle(hd_new),
		.done(cord_done),
		.sin_out(sin_v),
		.cos_out(cos_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			mpc_q <= ddeo_pkg::MPC_RESET;
			tpm_q <= ddeo_pkg::TPM_RESET;
			lbase_q <= '0;
			rbase_q <= '0;
			x_q <= '0;
			y_q <= '0;
			hd_q <= '0;
			pose_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					ddeo_pkg::REG_MPC: mpc_q <= cfg_data;
					ddeo_pkg::REG_TPM: tpm_q <= cfg_data;
					default: ;
				endcase
			end
			if (fin_go) begin
				pose_valid_q <= 1'b1;
			end else if (pose_valid_q && pose_ready) begin
				pose_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						case (cmd_data.cmd)
							ddeo_pkg::CMD_SAMPLE: begin
								lbase_q <= cmd_data.left_angle;
								rbase_q <= cmd_data.right_angle;
								state_q <= ST_MUL1;
							end
							ddeo_pkg::CMD_LOAD: begin
								x_q <= cmd_data.load_x;
								y_q <= cmd_data.load_y;
								hd_q <= cmd_data.load_heading;
								state_q <= ST_FIN;
							end
							ddeo_pkg::CMD_CAPTURE: begin
								lbase_q <= cmd_data.left_angle;
								rbase_q <= cmd_data.right_angle;
								state_q <= ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_MUL1: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						hd_q <= hd_new;
						state_q <= ST_CORD;
					end
				end
				ST_CORD: begin
					if (cord_done) begin
						x_q <= sat32(x_sum);
						y_q <= sat32(y_sum);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bit-serial shift-add multipliers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mcd_q <= WP'(dl - dr);
				mcs_q <= WP'(dl + dr);
				accd_q <= '0;
				accs_q <= '0;
				mpl_q <= mpc_q;
			end
			ST_MUL1: begin
				if (mpl_q[0]) begin
					accd_q <= accd_q + mcd_q;
					accs_q <= accs_q + mcs_q;
				end
				mcd_q <= mcd_q <<< 1;
				mcs_q <= mcs_q <<< 1;
				if (cnt_q == 5'd31) begin
					mch_q <= WH'(mpl_q[0] ? accd_q + mcd_q : accd_q);
					mpl_q <= tpm_q;
					gain_q <= ddeo_pkg::CORDIC_GAIN;
					acch_q <= '0;
					accm_q <= '0;
				end else begin
					mpl_q <= mpl_q >> 1;
				end
			end
			ST_MUL2: begin
				if (cnt_q == 5'd0) begin
					mcm_q <= WM'(m16);
				end else begin
					mcm_q <= mcm_q <<< 1;
					if (gain_q[0]) begin
						accm_q <= accm_q + mcm_q;
					end
					gain_q <= gain_q >> 1;
				end
				if (mpl_q[0]) begin
					acch_q <= acch_q + mch_q;
				end
				mch_q <= mch_q << 1;
				mpl_q <= mpl_q >> 1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			pose_q.pos_x <= x_q;
			pose_q.pos_y <= y_q;
			pose_q.heading <= hd_q;
		end
	end

	assign pose_valid = pose_valid_q;
	assign pose_data = pose_q;

	`DDEO_ASSERT(a_busy_after_accept, accept |=> !cmd_ready, "ready after accept")
	`DDEO_NEVER(a_done_out_of_cord, cord_done && (state_q != ST_CORD), "stray cordic done")
	`DDEO_ASSERT(a_fin_shows, fin_go |=> pose_valid, "result not shown")
endmodule
`default_nettype wire
